// File: hdl/cgaf_pkg.sv
// cgaf_pkg: shared types, fixed-point constants and helpers for the cuboid
// gap adhesion force pipeline. Used by every file in hdl/ except cgaf_intf.
package cgaf_pkg;

  localparam int DW = 32;
  localparam int FB = 16;

  localparam logic [31:0]        MAX_MAG  = 32'h7FFF_FFFF;
  localparam logic signed [31:0] MAX_VAL  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_VAL  = 32'sh8000_0000;
  localparam logic [15:0]        RND_HALF = 16'h8000;
  localparam logic [16:0]        ONE_Q    = 17'h1_0000;

  // log2(e), ln(2) and exp(-0.5) in Q16.16
  localparam logic [16:0] LOG2E_Q = 17'd94548;
  localparam logic [15:0] LN2_Q   = 16'd45426;
  localparam logic [15:0] E_HALF  = 16'd39749;

  localparam logic [30:0] ZETA_RST      = 31'd65536;
  localparam logic [30:0] INV_RANGE_RST = 31'd65536;
  localparam logic [31:0] C1_RST        = 32'd46340;
  localparam logic [31:0] C2_RST        = 32'd28106;

  localparam int SQRT_STEPS    = 32;
  localparam int HORNER_TERMS  = 9;
  localparam int RECIP_SHIFT   = 21;
  localparam int EXP_LAT       = 4 + 2 * HORNER_TERMS + 1;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZETA      = 2'd0,
    REG_INV_RANGE = 2'd1,
    REG_NEWTON    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [30:0] zeta;
    logic [30:0] inv_range;
    logic        newton;
    logic [31:0] c1;
    logic [31:0] c2;
    logic        busy;
  } cfg_t;

  function automatic logic [31:0] mag_of(input logic signed [31:0] v);
    mag_of = v[31] ? $unsigned(-v) : $unsigned(v);
  endfunction

  // round to nearest (ties away) at FB, saturate to DW bits, apply sign
  function automatic logic signed [31:0] rnd_sat(input logic neg, input logic [63:0] mag);
    logic [64:0]    sum;
    logic [64-FB:0] r;
    sum = {1'b0, mag} + 65'(RND_HALF);
    r   = sum[64:FB];
    if (r > (65-FB)'(MAX_MAG)) begin
      rnd_sat = neg ? MIN_VAL : MAX_VAL;
    end else begin
      rnd_sat = neg ? -$signed(r[31:0]) : $signed(r[31:0]);
    end
  endfunction

  // ceil(2^RECIP_SHIFT / k): exact floor division for dividends below 2^17
  function automatic logic [21:0] recip(input logic [3:0] k);
    case (k)
      4'd1:    recip = 22'd2097152;
      4'd2:    recip = 22'd1048576;
      4'd3:    recip = 22'd699051;
      4'd4:    recip = 22'd524288;
      4'd5:    recip = 22'd419431;
      4'd6:    recip = 22'd349526;
      4'd7:    recip = 22'd299594;
      4'd8:    recip = 22'd262144;
      4'd9:    recip = 22'd233017;
      default: recip = 22'd0;
    endcase
  endfunction

endpackage

// File: hdl/cgaf_intf.sv
// cgaf_intf: valid/ready channel interfaces for pair items and force results.
// Depends on nothing.
interface cgaf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] dz;
  logic        [30:0] sum_w;
  logic        [30:0] sum_d;
  logic        [30:0] sum_h;
  logic signed [31:0] pair_coeff;
  logic               j_is_local;

  modport source (output valid, dx, dy, dz, sum_w, sum_d, sum_h, pair_coeff, j_is_local,
                  input ready);
  modport sink (input valid, dx, dy, dz, sum_w, sum_d, sum_h, pair_coeff, j_is_local,
                output ready);
endinterface

interface cgaf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fx;
  logic signed [31:0] fy;
  logic signed [31:0] fz;
  logic               apply_to_j;

  modport source (output valid, fx, fy, fz, apply_to_j, input ready);
  modport sink (input valid, fx, fy, fz, apply_to_j, output ready);
endinterface

// File: hdl/cuboid_gap_adhesion_force.sv
// cuboid_gap_adhesion_force: top level of the pair adhesion force pipeline.
// Uses cgaf_pkg, cgaf_intf, cgaf_cfg, cgaf_sqrt and cgaf_exp.
//
// Usage:
//   in_ch  : one neighbor pair per transfer (dx, dy, dz, summed half-extents,
//            pair_coeff, j_is_local), valid/ready.
//   out_ch : one result per pair (fx, fy, fz, apply_to_j), in input order.
//   cfg_*  : write port; index 0 zeta, 1 inv_range, 2 reaction flag, 3 ignored.
// 71 register stages, the first loaded at the input transfer edge: 3 gap/square/sum
// stages, 32 square-root stages (one result bit each), 7 stages to the exp
// arguments, 23 exp stages (two per Horner term) and 6 force stages.
// One pair per cycle while not stalled or busy; every stage holds one pair.
// in_ch.ready is low in the cycle of a zeta write and during the c1/c2 update
// after it (48 divide steps, 24 square root steps, one multiply).
// Reset (synchronous, rst_n low) empties the pipeline and restores the
// registers to zeta 1.0, inv_range 1.0, reaction flag 0 with matching c1, c2.
// When out_ch holds a result that is not taken, the whole pipeline holds and
// in_ch.ready is low; nothing is dropped or repeated.
module cuboid_gap_adhesion_force (
  input  logic                             clk,
  input  logic                             rst_n,
  cgaf_in_if.sink                          in_ch,
  cgaf_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [cgaf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [cgaf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SIDE_LEN = 3 + cgaf_pkg::SQRT_STEPS + 7 + cgaf_pkg::EXP_LAT + 5;
  localparam int AF_TAP   = SIDE_LEN - 4;
  localparam int D_TAP    = SIDE_LEN - 2;
  localparam int A_LEN    = 4 + cgaf_pkg::EXP_LAT;

  typedef struct packed {
    logic [2:0][31:0] d;
    logic [31:0]      af;
    logic             jl;
  } side_t;

  cgaf_pkg::cfg_t cfg;

  cgaf_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  logic en;
  logic in_xfer;
  logic vout_r;

  assign en          = !vout_r || out_ch.ready;
  assign in_ch.ready = en && !cfg.busy && !(cfg_we && cfg_idx == cgaf_pkg::REG_ZETA);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  function automatic logic [31:0] axis_gap(input logic signed [31:0] d, input logic [30:0] ext);
    logic [31:0] m;
    m = cgaf_pkg::mag_of(d);
    axis_gap = (m > {1'b0, ext}) ? m - {1'b0, ext} : 32'd0;
  endfunction

  // gap, square, sum
  logic [2:0]  va_r;
  logic [31:0] gap_r [3];
  logic [63:0] sq_r  [3];
  logic [63:0] ssum_r;
  side_t       side_r [SIDE_LEN];
  side_t       side_in;

  assign side_in.d  = {in_ch.dz, in_ch.dy, in_ch.dx};
  assign side_in.af = in_ch.pair_coeff;
  assign side_in.jl = in_ch.j_is_local;

  // sqrt output
  logic        vs;
  logic [31:0] root;
  logic [31:0] g;

  // rij and exponent arguments
  logic [6:0]         vb_r;
  logic [63:0]        prij_r;
  logic signed [31:0] rij_r;
  logic [30:0]        rij38_r;
  logic [30:0]        a_r;
  logic [61:0]        paa_r, prr_r;
  logic signed [31:0] aa_r, rr_r;
  logic [61:0]        pza_r, pzr_r;
  logic signed [31:0] xa_r, xr_r;
  logic [30:0]        aln_r [A_LEN];
  logic [31:0]        a_sum;

  // exp results
  logic        ve1, ve2;
  logic [16:0] e1, e2;

  // force
  logic [4:0]         vc_r;
  logic [63:0]        pa_r, pc_r;
  logic signed [31:0] term_r;
  logic               pf_neg_r;
  logic [63:0]        pf_mag_r;
  logic signed [31:0] scale_r;
  logic signed [31:0] sv;
  logic               pd_neg_r [3];
  logic [63:0]        pd_mag_r [3];
  logic signed [31:0] f_r [3];
  logic               apply_r;

  assign a_sum = {1'b0, rij_r[30:0]} + {1'b0, cfg.c1[30:0]};
  assign g     = root[31] ? cgaf_pkg::MAX_MAG : root;
  assign sv    = cgaf_pkg::rnd_sat(pf_neg_r, pf_mag_r);

  cgaf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (va_r[2]),
    .v_i   (ssum_r),
    .vld_o (vs),
    .res_o (root)
  );

  cgaf_exp u_exp_a (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (vb_r[6]),
    .x_i   (xa_r),
    .vld_o (ve1),
    .e_o   (e1)
  );

  cgaf_exp u_exp_r (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (vb_r[6]),
    .x_i   (xr_r),
    .vld_o (ve2),
    .e_o   (e2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= '0;
      vb_r   <= '0;
      vc_r   <= '0;
      vout_r <= 1'b0;
    end else if (en) begin
      va_r   <= {va_r[1:0], in_xfer};
      vb_r   <= {vb_r[5:0], vs};
      vc_r   <= {vc_r[3:0], ve1 && ve2};
      vout_r <= vc_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gap_r[0]  <= axis_gap(in_ch.dx, in_ch.sum_w);
      gap_r[1]  <= axis_gap(in_ch.dy, in_ch.sum_d);
      gap_r[2]  <= axis_gap(in_ch.dz, in_ch.sum_h);
      side_r[0] <= side_in;
      for (int i = 1; i < SIDE_LEN; i++) begin
        side_r[i] <= side_r[i-1];
      end
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 64'(gap_r[i]) * 64'(gap_r[i]);
      end
      ssum_r <= sq_r[0] + sq_r[1] + sq_r[2];

      prij_r  <= 64'(g) * 64'(cfg.inv_range);
      rij_r   <= cgaf_pkg::rnd_sat(1'b0, prij_r);
      rij38_r <= rij_r[30:0];
      a_r     <= a_sum[31] ? 31'h7FFF_FFFF : a_sum[30:0];
      paa_r   <= 62'(a_r) * 62'(a_r);
      prr_r   <= 62'(rij38_r) * 62'(rij38_r);
      aa_r    <= cgaf_pkg::rnd_sat(1'b0, 64'(paa_r));
      rr_r    <= cgaf_pkg::rnd_sat(1'b0, 64'(prr_r));
      pza_r   <= 62'(cfg.zeta) * 62'(aa_r[30:0]);
      pzr_r   <= 62'(cfg.zeta) * 62'(rr_r[30:0]);
      xa_r    <= cgaf_pkg::rnd_sat(1'b0, 64'(pza_r));
      xr_r    <= cgaf_pkg::rnd_sat(1'b0, 64'(pzr_r));
      aln_r[0] <= a_r;
      for (int i = 1; i < A_LEN; i++) begin
        aln_r[i] <= aln_r[i-1];
      end

      pa_r     <= 64'(aln_r[A_LEN-1]) * 64'(e1);
      pc_r     <= 64'(cfg.c2) * 64'(e2);
      term_r   <= cgaf_pkg::rnd_sat(1'b0, pa_r) - cgaf_pkg::rnd_sat(1'b0, pc_r);
      pf_neg_r <= side_r[AF_TAP].af[31] ^ term_r[31];
      pf_mag_r <= 64'(cgaf_pkg::mag_of(side_r[AF_TAP].af)) * 64'(cgaf_pkg::mag_of(term_r));
      scale_r  <= (sv == cgaf_pkg::MIN_VAL) ? cgaf_pkg::MAX_VAL : -sv;
      for (int i = 0; i < 3; i++) begin
        pd_neg_r[i] <= side_r[D_TAP].d[i][31] ^ scale_r[31];
        pd_mag_r[i] <= 64'(cgaf_pkg::mag_of(side_r[D_TAP].d[i])) *
                       64'(cgaf_pkg::mag_of(scale_r));
        f_r[i]      <= cgaf_pkg::rnd_sat(pd_neg_r[i], pd_mag_r[i]);
      end
      apply_r <= side_r[SIDE_LEN-1].jl | cfg.newton;
    end
  end

  assign out_ch.valid      = vout_r;
  assign out_ch.fx         = f_r[0];
  assign out_ch.fy         = f_r[1];
  assign out_ch.fz         = f_r[2];
  assign out_ch.apply_to_j = apply_r;

endmodule

// File: hdl/cgaf_cfg.sv
// cgaf_cfg: configuration registers and the sequencer that derives c1, c2
// from zeta (restoring divide, bit-serial square root, one multiply). Uses cgaf_pkg.
module cgaf_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cgaf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [cgaf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cgaf_pkg::cfg_t                   cfg
);

  localparam int DIV_STEPS = 3 * cgaf_pkg::FB;
  localparam int RT_STEPS  = DIV_STEPS / 2;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SQRT, ST_MUL} state_t;

  state_t      state_r;
  logic [30:0] zeta_r;
  logic [30:0] inv_range_r;
  logic        newton_r;
  logic [31:0] c1_r;
  logic [31:0] c2_r;
  logic [31:0] rem_r;
  logic [47:0] quo_r;
  logic [47:0] res_r;
  logic [47:0] bit_r;
  logic [5:0]  cnt_r;

  logic [31:0] rem_s;
  logic        ge;
  logic [47:0] trial;

  assign rem_s = {rem_r[30:0], (cnt_r == 6'd0)};
  assign ge    = (rem_s >= {1'b0, zeta_r});
  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      zeta_r      <= cgaf_pkg::ZETA_RST;
      inv_range_r <= cgaf_pkg::INV_RANGE_RST;
      newton_r    <= 1'b0;
      c1_r        <= cgaf_pkg::C1_RST;
      c2_r        <= cgaf_pkg::C2_RST;
    end else begin
      if (cfg_we && cfg_idx == cgaf_pkg::REG_INV_RANGE) begin
        inv_range_r <= cfg_data;
      end
      if (cfg_we && cfg_idx == cgaf_pkg::REG_NEWTON) begin
        newton_r <= cfg_data[0];
      end
      if (cfg_we && cfg_idx == cgaf_pkg::REG_ZETA) begin
        zeta_r  <= cfg_data;
        state_r <= ST_DIV;
        rem_r   <= '0;
        quo_r   <= '0;
        cnt_r   <= '0;
      end else begin
        unique case (state_r)
          ST_IDLE: begin
          end
          ST_DIV: begin
            if (zeta_r == '0) begin
              c1_r    <= cgaf_pkg::MAX_MAG;
              state_r <= ST_MUL;
            end else begin
              rem_r <= ge ? rem_s - {1'b0, zeta_r} : rem_s;
              quo_r <= {quo_r[46:0], ge};
              cnt_r <= cnt_r + 6'd1;
              if (cnt_r == 6'(DIV_STEPS - 1)) begin
                state_r <= ST_SQRT;
                res_r   <= '0;
                bit_r   <= 48'd1 << 46;
                cnt_r   <= '0;
              end
            end
          end
          ST_SQRT: begin
            if (quo_r >= trial) begin
              quo_r <= quo_r - trial;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
            cnt_r <= cnt_r + 6'd1;
            if (cnt_r == 6'(RT_STEPS - 1)) begin
              c1_r    <= (quo_r >= trial) ? 32'((res_r >> 1) + bit_r) : 32'(res_r >> 1);
              state_r <= ST_MUL;
            end
          end
          ST_MUL: begin
            c2_r    <= cgaf_pkg::rnd_sat(1'b0, 64'(c1_r) * 64'(cgaf_pkg::E_HALF));
            state_r <= ST_IDLE;
          end
          default: state_r <= ST_IDLE;
        endcase
      end
    end
  end

  assign cfg.zeta      = zeta_r;
  assign cfg.inv_range = inv_range_r;
  assign cfg.newton    = newton_r;
  assign cfg.c1        = c1_r;
  assign cfg.c2        = c2_r;
  assign cfg.busy      = (state_r != ST_IDLE);

endmodule

// File: hdl/cgaf_sqrt.sv
// cgaf_sqrt: pipelined 64-bit integer square root, one result bit per stage.
// Uses cgaf_pkg.
module cgaf_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [63:0] v_i,
  output logic        vld_o,
  output logic [31:0] res_o
);

  localparam int N = cgaf_pkg::SQRT_STEPS;

  logic [N-1:0] vld_r;
  logic [63:0]  v_r   [N];
  logic [63:0]  r_r   [N];
  logic [63:0]  v_nxt [N];
  logic [63:0]  r_nxt [N];
  logic [63:0]  v_src [N];
  logic [63:0]  r_src [N];

  always_comb begin
    v_src[0] = v_i;
    r_src[0] = '0;
    for (int k = 1; k < N; k++) begin
      v_src[k] = v_r[k-1];
      r_src[k] = r_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      logic [63:0] bitv;
      logic [63:0] trial;
      bitv  = 64'd1 << (62 - 2 * k);
      trial = r_src[k] + bitv;
      if (v_src[k] >= trial) begin
        v_nxt[k] = v_src[k] - trial;
        r_nxt[k] = (r_src[k] >> 1) + bitv;
      end else begin
        v_nxt[k] = v_src[k];
        r_nxt[k] = r_src[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
      r_r <= r_nxt;
    end
  end

  assign vld_o = vld_r[N-1];
  assign res_o = r_r[N-1][31:0];

endmodule

// File: hdl/cgaf_exp.sv
// cgaf_exp: pipelined exp(-x) for x >= 0: base-2 split, ln2 scaling and a
// nine-term Horner series, two stages per term. Uses cgaf_pkg.
module cgaf_exp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic signed [31:0] x_i,
  output logic               vld_o,
  output logic [16:0]        e_o
);

  localparam int L = cgaf_pkg::EXP_LAT;
  localparam int H = cgaf_pkg::HORNER_TERMS;

  logic [L-1:0] vld_r;
  logic [47:0]  py_r;
  logic [14:0]  n1_r, n2_r, n3_r;
  logic [15:0]  f1_r;
  logic [31:0]  pt_r;
  logic [15:0]  t3_r;
  logic [16:0]  e_r;

  logic [16:0]  tpa_r  [H];
  logic [15:0]  ta_r   [H];
  logic [14:0]  na_r   [H];
  logic [16:0]  pb_r   [H];
  logic [15:0]  tb_r   [H];
  logic [14:0]  nb_r   [H];
  logic [16:0]  tpa_nxt[H];
  logic [16:0]  pb_nxt [H];
  logic [16:0]  p_src  [H];
  logic [15:0]  t_src  [H];
  logic [14:0]  n_src  [H];

  logic signed [31:0] y;
  assign y = cgaf_pkg::rnd_sat(1'b0, 64'(py_r));

  always_comb begin
    p_src[0] = cgaf_pkg::ONE_Q;
    t_src[0] = t3_r;
    n_src[0] = n3_r;
    for (int j = 1; j < H; j++) begin
      p_src[j] = pb_r[j-1];
      t_src[j] = tb_r[j-1];
      n_src[j] = nb_r[j-1];
    end
    for (int j = 0; j < H; j++) begin
      logic [33:0] tp;
      logic [38:0] qm;
      tp         = 34'(t_src[j]) * 34'(p_src[j]) + 34'(cgaf_pkg::RND_HALF);
      tpa_nxt[j] = tp[32:16];
      qm         = 39'(tpa_r[j]) * 39'(cgaf_pkg::recip(4'(H - j)));
      pb_nxt[j]  = cgaf_pkg::ONE_Q - qm[37:cgaf_pkg::RECIP_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      py_r <= 48'(x_i[30:0]) * 48'(cgaf_pkg::LOG2E_Q);
      n1_r <= y[30:16];
      f1_r <= y[15:0];
      pt_r <= 32'(f1_r) * 32'(cgaf_pkg::LN2_Q);
      n2_r <= n1_r;
      t3_r <= 16'((33'(pt_r) + 33'(cgaf_pkg::RND_HALF)) >> 16);
      n3_r <= n2_r;
      tpa_r <= tpa_nxt;
      ta_r  <= t_src;
      na_r  <= n_src;
      pb_r  <= pb_nxt;
      tb_r  <= ta_r;
      nb_r  <= na_r;
      e_r   <= (nb_r[H-1] > 15'd16) ? 17'd0 : (pb_r[H-1] >> nb_r[H-1][4:0]);
    end
  end

  assign vld_o = vld_r[L-1];
  assign e_o   = e_r;

endmodule

// File: hdl/cgaf_chk.sv
// cgaf_chk: port-level checks for cuboid_gap_adhesion_force, attached by bind.
// Uses cgaf_pkg.
module cgaf_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [31:0]             out_fx,
  input logic                           out_apply_to_j,
  input logic                           cfg_we,
  input logic [cgaf_pkg::CFG_IDX_W-1:0] cfg_idx
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_fx) && $stable(out_apply_to_j))
    else $error("stalled result changed");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  a_zeta_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_idx == cgaf_pkg::REG_ZETA |-> !in_ready ##1 !in_ready)
    else $error("input taken during c1/c2 update");

  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind cuboid_gap_adhesion_force cgaf_chk u_cgaf_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_fx         (out_ch.fx),
  .out_apply_to_j (out_ch.apply_to_j),
  .cfg_we         (cfg_we),
  .cfg_idx        (cfg_idx)
);
